@@ hw/rtl/sia_pkg.sv @@
// Shared types and constants of the signed integer ALU.
`timescale 1ns / 1ps
package sia_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MOD  = 4'd4,
        OP_POW  = 4'd5,
        OP_AND  = 4'd6,
        OP_OR   = 4'd7,
        OP_XOR  = 4'd8,
        OP_SHL  = 4'd9,
        OP_SHR  = 4'd10,
        OP_CMP  = 4'd11,
        OP_NEG  = 4'd12,
        OP_NOT  = 4'd13,
        OP_TEST = 4'd14
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_DIV0  = 2'd1,
        ERR_SHIFT = 2'd2,
        ERR_OPC   = 2'd3
    } err_t;

    typedef struct packed {
        logic [3:0] op;
        err_t       err;
        logic       flags_fixed;
        logic       zf;
        logic       nf;
        logic       q_neg;
        logic       r_neg;
        logic       pow_special;
    } ctrl_t;

endpackage

@@ hw/rtl/sia_div_step.sv @@
// One registered step of the restoring divider on operand magnitudes.
`timescale 1ns / 1ps
module sia_div_step #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] rem_in,
    input  logic [W-1:0] quo_in,
    input  logic [W-1:0] den_in,
    output logic [W-1:0] rem_out,
    output logic [W-1:0] quo_out,
    output logic [W-1:0] den_out
);
    logic [W-1:0] rem_reg;
    logic [W-1:0] quo_reg;
    logic [W-1:0] den_reg;
    logic [W-1:0] rem_next;
    logic [W-1:0] quo_next;
    logic [W:0]   partial;
    logic [W:0]   diff;

    always_comb
    begin
        partial  = {rem_in, quo_in[W-1]};
        diff     = partial - {1'b0, den_in};
        rem_next = diff[W] ? partial[W-1:0] : diff[W-1:0];
        quo_next = {quo_in[W-2:0], ~diff[W]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            den_reg <= den_in;
        end
    end

    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign den_out = den_reg;
endmodule

@@ hw/rtl/sia_pow_step.sv @@
// One registered square-and-multiply step of the integer power.
`timescale 1ns / 1ps
module sia_pow_step #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] acc_in,
    input  logic [W-1:0] sq_in,
    input  logic [W-1:0] expo_in,
    output logic [W-1:0] acc_out,
    output logic [W-1:0] sq_out,
    output logic [W-1:0] expo_out
);
    logic [W-1:0] acc_reg;
    logic [W-1:0] sq_reg;
    logic [W-1:0] expo_reg;
    logic [W-1:0] acc_next;
    logic [W-1:0] sq_next;
    logic [W-1:0] expo_next;

    always_comb
    begin
        acc_next  = expo_in[0] ? acc_in * sq_in : acc_in;
        sq_next   = sq_in * sq_in;
        expo_next = expo_in >> 1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg  <= acc_next;
            sq_reg   <= sq_next;
            expo_reg <= expo_next;
        end
    end

    assign acc_out  = acc_reg;
    assign sq_out   = sq_reg;
    assign expo_out = expo_reg;
endmodule

@@ hw/rtl/signed_integer_alu.sv @@
// Top level of the pipelined signed integer ALU.
// Throughput: one request per cycle while the output is not stalled; the
// divider and power units have one registered stage per operand bit, so the
// pipeline is DATA_WIDTH + 2 deep.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits asynchronously; data registers are not reset.
`timescale 1ns / 1ps
module signed_integer_alu #(
    parameter int DATA_WIDTH = sia_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [3:0]            req_type,
    input  logic [DATA_WIDTH-1:0] left_operand,
    input  logic [DATA_WIDTH-1:0] right_operand,
    input  logic                  swap_operands,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] result_value,
    output logic                  zero_flag,
    output logic                  negative_flag,
    output logic [1:0]            error_code
);
    import sia_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int SW = $clog2(W);

    logic en;

    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] simple_next;
    ctrl_t        ctrl_next;

    logic         vld_reg  [0:W];
    ctrl_t        ctrl_s   [0:W];
    logic [W-1:0] simple_s [0:W];
    logic [W-1:0] rem_s    [0:W];
    logic [W-1:0] quo_s    [0:W];
    logic [W-1:0] den_s    [0:W];
    logic [W-1:0] acc_s    [0:W];
    logic [W-1:0] sq_s     [0:W];
    logic [W-1:0] expo_s   [0:W];

    ctrl_t        ctrl_reg;
    logic [W-1:0] simple_reg;
    logic [W-1:0] rem0_reg;
    logic [W-1:0] quo0_reg;
    logic [W-1:0] den0_reg;
    logic [W-1:0] sq0_reg;
    logic [W-1:0] expo0_reg;

    logic         out_valid_reg;
    logic [W-1:0] res_reg;
    logic         zf_reg;
    logic         nf_reg;
    logic [1:0]   err_reg;
    logic [W-1:0] res_next;
    logic         zf_next;
    logic         nf_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        a = swap_operands ? right_operand : left_operand;
        b = swap_operands ? left_operand : right_operand;
        simple_next = '0;
        ctrl_next = '0;
        ctrl_next.op = req_type;
        ctrl_next.err = ERR_NONE;
        ctrl_next.q_neg = a[W-1] ^ b[W-1];
        ctrl_next.r_neg = a[W-1];
        unique case (op_t'(req_type))
            OP_ADD: simple_next = a + b;
            OP_SUB: simple_next = a - b;
            OP_MUL: simple_next = a * b;
            OP_DIV, OP_MOD:
            begin
                if (b == '0)
                begin
                    ctrl_next.err = ERR_DIV0;
                end
            end
            OP_POW:
            begin
                ctrl_next.pow_special = b[W-1];
                if (a == W'(1))
                begin
                    simple_next = W'(1);
                end
                else if (a == '1)
                begin
                    simple_next = b[0] ? '1 : W'(1);
                end
            end
            OP_AND: simple_next = a & b;
            OP_OR:  simple_next = a | b;
            OP_XOR: simple_next = a ^ b;
            OP_SHL, OP_SHR:
            begin
                if (b[W-1] || (b >= W'(W)))
                begin
                    ctrl_next.err = ERR_SHIFT;
                end
                else if (op_t'(req_type) == OP_SHL)
                begin
                    simple_next = a << b[SW-1:0];
                end
                else
                begin
                    simple_next = $signed(a) >>> b[SW-1:0];
                end
            end
            OP_CMP:
            begin
                ctrl_next.flags_fixed = 1'b1;
                ctrl_next.zf = (a == b);
                ctrl_next.nf = $signed(a) < $signed(b);
            end
            OP_NEG: simple_next = -left_operand;
            OP_NOT: simple_next = ~left_operand;
            OP_TEST:
            begin
                ctrl_next.flags_fixed = 1'b1;
                ctrl_next.zf = (left_operand == '0);
                ctrl_next.nf = left_operand[W-1];
            end
            default: ctrl_next.err = ERR_OPC;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_reg   <= ctrl_next;
            simple_reg <= simple_next;
            rem0_reg   <= '0;
            quo0_reg   <= a[W-1] ? -a : a;
            den0_reg   <= b[W-1] ? -b : b;
            sq0_reg    <= a;
            expo0_reg  <= b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    assign ctrl_s[0]   = ctrl_reg;
    assign simple_s[0] = simple_reg;
    assign rem_s[0]    = rem0_reg;
    assign quo_s[0]    = quo0_reg;
    assign den_s[0]    = den0_reg;
    assign acc_s[0]    = W'(1);
    assign sq_s[0]     = sq0_reg;
    assign expo_s[0]   = expo0_reg;

    for (genvar i = 1; i <= W; i++)
    begin : g_stage
        ctrl_t        ctrl_stage_reg;
        logic [W-1:0] simple_stage_reg;

        sia_div_step #(.W(W)) u_div (
            .clk     (clk),
            .en      (en),
            .rem_in  (rem_s[i-1]),
            .quo_in  (quo_s[i-1]),
            .den_in  (den_s[i-1]),
            .rem_out (rem_s[i]),
            .quo_out (quo_s[i]),
            .den_out (den_s[i])
        );

        sia_pow_step #(.W(W)) u_pow (
            .clk      (clk),
            .en       (en),
            .acc_in   (acc_s[i-1]),
            .sq_in    (sq_s[i-1]),
            .expo_in  (expo_s[i-1]),
            .acc_out  (acc_s[i]),
            .sq_out   (sq_s[i]),
            .expo_out (expo_s[i])
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctrl_stage_reg   <= ctrl_s[i-1];
                simple_stage_reg <= simple_s[i-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end

        assign ctrl_s[i]   = ctrl_stage_reg;
        assign simple_s[i] = simple_stage_reg;
    end

    always_comb
    begin
        unique case (ctrl_s[W].op)
            OP_DIV:  res_next = ctrl_s[W].q_neg ? -quo_s[W] : quo_s[W];
            OP_MOD:  res_next = ctrl_s[W].r_neg ? -rem_s[W] : rem_s[W];
            OP_POW:  res_next = ctrl_s[W].pow_special ? simple_s[W] : acc_s[W];
            default: res_next = simple_s[W];
        endcase
        if (ctrl_s[W].flags_fixed)
        begin
            res_next = '0;
            zf_next  = ctrl_s[W].zf;
            nf_next  = ctrl_s[W].nf;
        end
        else
        begin
            zf_next = (res_next == '0);
            nf_next = res_next[W-1];
        end
        if (ctrl_s[W].err != ERR_NONE)
        begin
            res_next = '0;
            zf_next  = 1'b0;
            nf_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            zf_reg  <= zf_next;
            nf_reg  <= nf_next;
            err_reg <= ctrl_s[W].err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[W];
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_value  = res_reg;
    assign zero_flag     = zf_reg;
    assign negative_flag = nf_reg;
    assign error_code    = err_reg;
endmodule

@@ hw/rtl/sia_checker.sv @@
// Port-level assertions for the signed integer ALU and their binding.
`timescale 1ns / 1ps
module sia_checker #(
    parameter int W = sia_pkg::DATA_WIDTH_DEF
) (
    input logic         clk,
    input logic         rst_n,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input logic [W-1:0] result_value,
    input logic         zero_flag,
    input logic         negative_flag,
    input logic [1:0]   error_code
);
    import sia_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value))
        else $error("Stalled result changed.");

    a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code != ERR_NONE) |->
        (result_value == '0) && !zero_flag && !negative_flag)
        else $error("Error result carries data or flags.");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_value != '0) |-> !zero_flag)
        else $error("Zero flag set on a nonzero result.");

    a_neg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_value[W-1] |-> negative_flag)
        else $error("Negative result without negative flag.");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("Pipeline stalled with a free output.");
endmodule

bind signed_integer_alu sia_checker #(.W(DATA_WIDTH)) u_sia_checker (.*);

@@ test/tb_signed_integer_alu.sv @@
// Self-checking testbench of the pipelined signed integer ALU.
`timescale 1ns / 1ps
module tb_signed_integer_alu;
    import sia_pkg::*;

    localparam int W = 32;
    localparam int LATENCY = W + 2;
    localparam int RANDOM_COUNT = 1830;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [W-1:0] MIN_INT = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAX_INT = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
    localparam logic [3:0] OPCODE_UNKNOWN = 4'd15;

    typedef struct {
        logic [3:0]   opcode;
        logic [W-1:0] lhs;
        logic [W-1:0] rhs;
        logic         swap;
    } alu_request_t;

    typedef struct {
        logic [W-1:0] value;
        logic         zf;
        logic         nf;
        err_t         err;
    } alu_answer_t;

    typedef struct {
        alu_request_t req;
        logic         typed;
        alu_answer_t  ans;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [3:0] req_type;
    logic [W-1:0] left_operand;
    logic [W-1:0] right_operand;
    logic swap_operands;
    logic out_valid;
    logic out_ready;
    logic [W-1:0] result_value;
    logic zero_flag;
    logic negative_flag;
    logic [1:0] error_code;

    alu_answer_t pending_answers[$];
    int failures;
    longint cycles;
    bit calm_stretch;

    signed_integer_alu #(.DATA_WIDTH(W)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(req_type),
        .left_operand(left_operand),
        .right_operand(right_operand),
        .swap_operands(swap_operands),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_value(result_value),
        .zero_flag(zero_flag),
        .negative_flag(negative_flag),
        .error_code(error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [W-1:0] wrapped_power(logic [W-1:0] base, logic [W-1:0] expo);
        logic [W-1:0] acc;
        logic [W-1:0] sq;
        acc = 1;
        sq = base;
        if (expo[W-1])
        begin
            if (base == 1)
                return 1;
            if (base == ALL_ONES)
                return expo[0] ? ALL_ONES : 1;
            return 0;
        end
        while (expo != 0)
        begin
            if (expo[0])
                acc = acc * sq;
            sq = sq * sq;
            expo = expo >> 1;
        end
        return acc;
    endfunction

    function automatic alu_answer_t alu_outcome(alu_request_t r);
        alu_answer_t o;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] ma;
        logic [W-1:0] mb;
        logic from_result;
        a = r.swap ? r.rhs : r.lhs;
        b = r.swap ? r.lhs : r.rhs;
        ma = a[W-1] ? -a : a;
        mb = b[W-1] ? -b : b;
        o.value = 0;
        o.zf = 1'b0;
        o.nf = 1'b0;
        o.err = ERR_NONE;
        from_result = 1'b1;
        case (r.opcode)
            OP_ADD: o.value = a + b;
            OP_SUB: o.value = a - b;
            OP_MUL: o.value = a * b;
            OP_DIV:
                if (b == 0) o.err = ERR_DIV0;
                else o.value = (a[W-1] ^ b[W-1]) ? -(ma / mb) : ma / mb;
            OP_MOD:
                if (b == 0) o.err = ERR_DIV0;
                else o.value = a[W-1] ? -(ma % mb) : ma % mb;
            OP_POW: o.value = wrapped_power(a, b);
            OP_AND: o.value = a & b;
            OP_OR: o.value = a | b;
            OP_XOR: o.value = a ^ b;
            OP_SHL:
                if (b[W-1] || b >= W) o.err = ERR_SHIFT;
                else o.value = a << b;
            OP_SHR:
                if (b[W-1] || b >= W) o.err = ERR_SHIFT;
                else o.value = $signed(a) >>> b;
            OP_CMP:
            begin
                from_result = 1'b0;
                o.zf = (a == b);
                o.nf = $signed(a) < $signed(b);
            end
            OP_NEG: o.value = -r.lhs;
            OP_NOT: o.value = ~r.lhs;
            OP_TEST:
            begin
                from_result = 1'b0;
                o.zf = (r.lhs == 0);
                o.nf = r.lhs[W-1];
            end
            default: o.err = ERR_OPC;
        endcase
        if (o.err != ERR_NONE)
        begin
            o.value = 0;
            o.zf = 1'b0;
            o.nf = 1'b0;
        end
        else if (from_result)
        begin
            o.zf = (o.value == 0);
            o.nf = o.value[W-1];
        end
        return o;
    endfunction

    function automatic logic [W-1:0] random_operand();
        case ($urandom_range(0, 9))
            0: return MIN_INT;
            1: return MAX_INT;
            2: return ALL_ONES;
            3: return $urandom_range(0, 2);
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic bit take_break();
        return !calm_stretch && ($urandom_range(0, 99) < 14);
    endfunction

    function automatic directed_row_t row(logic [3:0] op, logic [W-1:0] l, logic [W-1:0] r,
                                          logic s, logic typed, logic [W-1:0] v,
                                          logic z, logic n, err_t e);
        directed_row_t d;
        d.req = '{op, l, r, s};
        d.typed = typed;
        d.ans = '{v, z, n, e};
        return d;
    endfunction

    task automatic send_request(alu_request_t r);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r.opcode;
        left_operand <= r.lhs;
        right_operand <= r.rhs;
        swap_operands <= r.swap;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        out_ready <= !take_break();
        if (out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %h %b %b %0d", $time,
                         result_value, zero_flag, negative_flag, error_code);
                failures++;
            end
            else
            begin
                alu_answer_t e;
                e = pending_answers.pop_front();
                if (result_value !== e.value || zero_flag !== e.zf ||
                    negative_flag !== e.nf || error_code !== e.err)
                begin
                    $display("%0t: mismatch, expected %h %b %b %0d, actual %h %b %b %0d",
                             $time, e.value, e.zf, e.nf, e.err, result_value, zero_flag,
                             negative_flag, error_code);
                    failures++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        directed_row_t rows[$];
        alu_request_t r;
        in_valid = 1'b0;
        out_ready = 1'b0;
        req_type = OP_ADD;
        left_operand = 0;
        right_operand = 0;
        swap_operands = 1'b0;
        failures = 0;
        cycles = 0;
        calm_stretch = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(row(OP_ADD, MAX_INT, 1, 0, 1, MIN_INT, 0, 1, ERR_NONE));
        rows.push_back(row(OP_SUB, MIN_INT, 1, 0, 1, MAX_INT, 0, 0, ERR_NONE));
        rows.push_back(row(OP_SUB, 5, 7, 1, 1, 2, 0, 0, ERR_NONE));
        rows.push_back(row(OP_MUL, MIN_INT, ALL_ONES, 0, 0, 0, 0, 0, ERR_NONE));
        rows.push_back(row(OP_DIV, 9, 0, 0, 1, 0, 0, 0, ERR_DIV0));
        rows.push_back(row(OP_MOD, 9, 0, 0, 1, 0, 0, 0, ERR_DIV0));
        rows.push_back(row(OP_DIV, MIN_INT, ALL_ONES, 0, 1, MIN_INT, 0, 1, ERR_NONE));
        rows.push_back(row(OP_MOD, MIN_INT, ALL_ONES, 0, 1, 0, 1, 0, ERR_NONE));
        rows.push_back(row(OP_MOD, -7, 2, 0, 1, ALL_ONES, 0, 1, ERR_NONE));
        rows.push_back(row(OP_DIV, -7, 2, 0, 0, 0, 0, 0, ERR_NONE));
        rows.push_back(row(OP_POW, 0, 0, 0, 1, 1, 0, 0, ERR_NONE));
        rows.push_back(row(OP_POW, 1, ALL_ONES, 0, 1, 1, 0, 0, ERR_NONE));
        rows.push_back(row(OP_POW, ALL_ONES, -3, 0, 1, ALL_ONES, 0, 1, ERR_NONE));
        rows.push_back(row(OP_POW, ALL_ONES, MIN_INT, 0, 1, 1, 0, 0, ERR_NONE));
        rows.push_back(row(OP_POW, 2, ALL_ONES, 0, 1, 0, 1, 0, ERR_NONE));
        rows.push_back(row(OP_POW, 3, 40, 0, 0, 0, 0, 0, ERR_NONE));
        rows.push_back(row(OP_AND, ALL_ONES, MIN_INT, 0, 0, 0, 0, 0, ERR_NONE));
        rows.push_back(row(OP_OR, 0, 0, 0, 0, 0, 0, 0, ERR_NONE));
        rows.push_back(row(OP_XOR, ALL_ONES, MAX_INT, 0, 0, 0, 0, 0, ERR_NONE));
        rows.push_back(row(OP_SHL, 1, W, 0, 1, 0, 0, 0, ERR_SHIFT));
        rows.push_back(row(OP_SHR, MIN_INT, ALL_ONES, 0, 1, 0, 0, 0, ERR_SHIFT));
        rows.push_back(row(OP_SHR, MIN_INT, W - 1, 0, 1, ALL_ONES, 0, 1, ERR_NONE));
        rows.push_back(row(OP_CMP, MIN_INT, MAX_INT, 0, 1, 0, 0, 1, ERR_NONE));
        rows.push_back(row(OP_NEG, MIN_INT, 3, 1, 1, MIN_INT, 0, 1, ERR_NONE));
        rows.push_back(row(OP_NOT, 0, 0, 0, 1, ALL_ONES, 0, 1, ERR_NONE));
        rows.push_back(row(OP_TEST, 0, 5, 1, 1, 0, 1, 0, ERR_NONE));
        rows.push_back(row(OPCODE_UNKNOWN, ALL_ONES, ALL_ONES, 1, 1, 0, 0, 0, ERR_OPC));

        foreach (rows[i])
        begin
            pending_answers.push_back(rows[i].typed ? rows[i].ans : alu_outcome(rows[i].req));
            send_request(rows[i].req);
        end

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            calm_stretch = (i >= 600 && i < 900);
            r.opcode = 4'($urandom_range(0, 15));
            r.lhs = random_operand();
            r.rhs = random_operand();
            r.swap = 1'($urandom_range(0, 1));
            if ((r.opcode == OP_SHL || r.opcode == OP_SHR) && $urandom_range(0, 3) != 0)
            begin
                if (r.swap)
                    r.lhs = $urandom_range(0, W - 1);
                else
                    r.rhs = $urandom_range(0, W - 1);
            end
            pending_answers.push_back(alu_outcome(r));
            send_request(r);
        end
        in_valid <= 1'b0;
        calm_stretch = 1'b0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
